/* sv/ign3d_pkg.sv */
package ign3d_pkg;

  // One write beat into a permutation copy
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } perm_wr_t;

  // Reference permutation loaded after reset
  localparam logic [7:0] PERM_INIT [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
    8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
    8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
    8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
    8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
    8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
    8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
    8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
    8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
    8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
    8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
    8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
    8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
    8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
    8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
    8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
    8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
    8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
    8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
    8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
    8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
    8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
    8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
    8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
    8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
    8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
    8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
    8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
  };

endpackage

/* sv/ign3d_perm_ram.sv */
module ign3d_perm_ram (
  input  logic                clk,
  input  ign3d_pkg::perm_wr_t wr,
  input  logic [7:0]          rd_addr_a,
  input  logic [7:0]          rd_addr_b,
  output logic [7:0]          rd_data_a_r,
  output logic [7:0]          rd_data_b_r
);
  import ign3d_pkg::*;

  logic [7:0] mem [256];

  // Write one entry, read two entries into registers
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

endmodule

/* sv/improved_gradient_noise_3d_core.sv */
// An accepted evaluate beat passes the stages below in order to its out_valid strobe.
// Throughput: one beat (evaluate or table write) per cycle while busy is low; a write gives no result.
// Seven copies of the permutation table give the 14 lookups per beat; a write
// beat updates each copy as it passes the stage that reads it.
// Reset: synchronous, active low; a load of all 256 entries of the reference
// permutation follows, with busy high. The receiver cannot stall.
module improved_gradient_noise_3d_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_coord_x,
  input  logic [31:0] in_coord_y,
  input  logic [31:0] in_coord_z,
  input  logic [7:0]  in_perm_index,
  input  logic [7:0]  in_perm_value,
  output logic        out_valid,
  output logic [16:0] out_noise_value
);
  import ign3d_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int SQW = 2 * F;
  localparam int PFW = F + 6;
  localparam int PW  = F + 4;
  localparam int CPW = SQW + PW - F;
  localparam int TW  = F + 1;
  localparam int GW  = F + 3;
  localparam int DW  = F + 4;
  localparam int MW  = TW + 1 + DW;
  localparam int QW  = F + 18;
  localparam logic [PFW-1:0]      TEN_P = PFW'(10) << F;
  localparam logic signed [GW-1:0] ONE_G = GW'(1 << F);
  localparam logic signed [GW:0]   TWO_G = (GW+1)'(2) <<< F;

  // Gradient dot product for one corner
  function automatic logic signed [GW-1:0] corner(input logic [7:0] h,
      input logic signed [GW-1:0] x, input logic signed [GW-1:0] y,
      input logic signed [GW-1:0] z);
    logic [3:0] k;
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    k = h[3:0];
    u = (k < 4'd8) ? x : y;
    v = (k < 4'd4) ? y : ((k == 4'd12 || k == 4'd14) ? x : z);
    return (k[0] ? -u : u) + (k[1] ? -v : v);
  endfunction

  // Finish a blend: lo + floor(product / 2^F)
  function automatic logic signed [GW-1:0] blend_add(input logic signed [GW-1:0] lo,
      input logic signed [MW-1:0] prod);
    logic signed [MW-1:0] s;
    s = MW'(lo) + (prod >>> F);
    return s[GW-1:0];
  endfunction

  // ---------------- table load after reset ----------------
  logic [8:0] init_cnt_r;
  logic       init_act;
  logic       acc;

  assign init_act = !init_cnt_r[8];
  assign busy     = init_act;
  assign acc      = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
    end else if (init_act) begin
      init_cnt_r <= init_cnt_r + 9'd1;
    end
  end

  perm_wr_t wr_init;
  assign wr_init = '{en: init_act, addr: init_cnt_r[7:0], data: PERM_INIT[init_cnt_r[7:0]]};

  // ---------------- stage 1: X lookups, squares ----------------
  logic [7:0]     in_ix, in_iy, in_iz;
  logic [F-1:0]   in_frac [3];
  logic           s1_vld_r, s1_func_r;
  logic [7:0]     s1_y_r, s1_z_r, s1_widx_r, s1_wval_r;
  logic [F-1:0]   s1_frac_r [3];
  logic [SQW-1:0] s1_sq_r [3];
  logic [7:0]     px0, px1;
  perm_wr_t       wr0;

  assign in_ix      = in_coord_x[F+7:F];
  assign in_iy      = in_coord_y[F+7:F];
  assign in_iz      = in_coord_z[F+7:F];
  assign in_frac[0] = in_coord_x[F-1:0];
  assign in_frac[1] = in_coord_y[F-1:0];
  assign in_frac[2] = in_coord_z[F-1:0];
  assign wr0 = init_act ? wr_init :
               perm_wr_t'{en: acc && in_func, addr: in_perm_index, data: in_perm_value};

  ign3d_perm_ram u_ram_x (
    .clk(clk), .wr(wr0), .rd_addr_a(in_ix), .rd_addr_b(in_ix + 8'd1),
    .rd_data_a_r(px0), .rd_data_b_r(px1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= acc;
    end
    s1_func_r <= in_func;
    s1_y_r    <= in_iy;
    s1_z_r    <= in_iz;
    s1_widx_r <= in_perm_index;
    s1_wval_r <= in_perm_value;
    for (int i = 0; i < 3; i++) begin
      s1_frac_r[i] <= in_frac[i];
      s1_sq_r[i]   <= SQW'(in_frac[i]) * SQW'(in_frac[i]);
    end
  end

  // ---------------- stage 2: A/B lookups, cube and fade poly ----------------
  logic [7:0]     ha, hb;
  logic [7:0]     pa0, pa1, pb0, pb1;
  logic           s2_vld_r, s2_func_r;
  logic [7:0]     s2_z_r, s2_widx_r, s2_wval_r;
  logic [F-1:0]   s2_frac_r [3];
  logic [SQW-1:0] s2_c2_r [3];
  logic [PW-1:0]  s2_p_r [3];
  logic [SQW+2:0] six_sq [3];
  logic [PFW-1:0] p_full [3];
  perm_wr_t       wr1;

  assign ha  = px0 + s1_y_r;
  assign hb  = px1 + s1_y_r;
  assign wr1 = init_act ? wr_init :
               perm_wr_t'{en: s1_vld_r && s1_func_r, addr: s1_widx_r, data: s1_wval_r};

  ign3d_perm_ram u_ram_a (
    .clk(clk), .wr(wr1), .rd_addr_a(ha), .rd_addr_b(ha + 8'd1),
    .rd_data_a_r(pa0), .rd_data_b_r(pa1)
  );
  ign3d_perm_ram u_ram_b (
    .clk(clk), .wr(wr1), .rd_addr_a(hb), .rd_addr_b(hb + 8'd1),
    .rd_data_a_r(pb0), .rd_data_b_r(pb1)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      six_sq[i] = (SQW+3)'(s1_sq_r[i]) * (SQW+3)'(6);
      p_full[i] = PFW'(six_sq[i] >> F) + TEN_P - PFW'(s1_frac_r[i]) * PFW'(15);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_func_r <= s1_func_r;
    s2_z_r    <= s1_z_r;
    s2_widx_r <= s1_widx_r;
    s2_wval_r <= s1_wval_r;
    for (int i = 0; i < 3; i++) begin
      s2_frac_r[i] <= s1_frac_r[i];
      s2_c2_r[i]   <= SQW'(s1_sq_r[i][SQW-1:F]) * SQW'(s1_frac_r[i]);
      s2_p_r[i]    <= p_full[i][PW-1:0];
    end
  end

  // ---------------- stage 3: corner lookups, fade product ----------------
  logic [7:0]     cbase [4];
  logic [7:0]     hsh [8];
  logic           s3_vld_r;
  logic [F-1:0]   s3_frac_r [3];
  logic [CPW-1:0] s3_cp_r [3];
  perm_wr_t       wr2;

  assign cbase[0] = pa0 + s2_z_r;
  assign cbase[1] = pb0 + s2_z_r;
  assign cbase[2] = pa1 + s2_z_r;
  assign cbase[3] = pb1 + s2_z_r;
  assign wr2 = init_act ? wr_init :
               perm_wr_t'{en: s2_vld_r && s2_func_r, addr: s2_widx_r, data: s2_wval_r};

  for (genvar k = 0; k < 4; k++) begin : g_corner_ram
    ign3d_perm_ram u_ram_c (
      .clk(clk), .wr(wr2), .rd_addr_a(cbase[k]), .rd_addr_b(cbase[k] + 8'd1),
      .rd_data_a_r(hsh[k]), .rd_data_b_r(hsh[k+4])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r && !s2_func_r;
    end
    for (int i = 0; i < 3; i++) begin
      s3_frac_r[i] <= s2_frac_r[i];
      s3_cp_r[i]   <= CPW'(s2_c2_r[i][SQW-1:F]) * CPW'(s2_p_r[i]);
    end
  end

  // ---------------- stage 4: gradients, fade values ----------------
  logic signed [GW-1:0] off0 [3];
  logic signed [GW-1:0] off1 [3];
  logic signed [GW-1:0] grad [8];
  logic                 s4_vld_r;
  logic [TW-1:0]        s4_t_r [3];
  logic signed [GW-1:0] s4_g_r [8];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off0[i] = $signed(GW'(s3_frac_r[i]));
      off1[i] = off0[i] - ONE_G;
    end
    for (int c = 0; c < 8; c++) begin
      grad[c] = corner(hsh[c], c[0] ? off1[0] : off0[0], c[1] ? off1[1] : off0[1],
                       c[2] ? off1[2] : off0[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
    for (int i = 0; i < 3; i++) begin
      s4_t_r[i] <= s3_cp_r[i][F+TW-1:F];
    end
    for (int c = 0; c < 8; c++) begin
      s4_g_r[c] <= grad[c];
    end
  end

  // ---------------- stages 5-6: blend along x ----------------
  logic                 s5_vld_r, s6_vld_r;
  logic signed [MW-1:0] s5_prod_r [4];
  logic signed [GW-1:0] s5_lo_r [4];
  logic [TW-1:0]        s5_tv_r, s5_tw_r, s6_tv_r, s6_tw_r;
  logic signed [GW-1:0] s6_l_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
    for (int k = 0; k < 4; k++) begin
      s5_prod_r[k] <= MW'($signed({1'b0, s4_t_r[0]})) *
                      MW'(DW'(s4_g_r[2*k+1]) - DW'(s4_g_r[2*k]));
      s5_lo_r[k]   <= s4_g_r[2*k];
      s6_l_r[k]    <= blend_add(s5_lo_r[k], s5_prod_r[k]);
    end
    s5_tv_r <= s4_t_r[1];
    s5_tw_r <= s4_t_r[2];
    s6_tv_r <= s5_tv_r;
    s6_tw_r <= s5_tw_r;
  end

  // ---------------- stages 7-8: blend along y ----------------
  logic                 s7_vld_r, s8_vld_r;
  logic signed [MW-1:0] s7_prod_r [2];
  logic signed [GW-1:0] s7_lo_r [2];
  logic [TW-1:0]        s7_tw_r, s8_tw_r;
  logic signed [GW-1:0] s8_l_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else begin
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
    end
    for (int k = 0; k < 2; k++) begin
      s7_prod_r[k] <= MW'($signed({1'b0, s6_tv_r})) *
                      MW'(DW'(s6_l_r[2*k+1]) - DW'(s6_l_r[2*k]));
      s7_lo_r[k]   <= s6_l_r[2*k];
      s8_l_r[k]    <= blend_add(s7_lo_r[k], s7_prod_r[k]);
    end
    s7_tw_r <= s6_tw_r;
    s8_tw_r <= s7_tw_r;
  end

  // ---------------- stages 9-10: blend along z ----------------
  logic                 s9_vld_r, s10_vld_r;
  logic signed [MW-1:0] s9_prod_r;
  logic signed [GW-1:0] s9_lo_r, s10_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r  <= 1'b0;
      s10_vld_r <= 1'b0;
    end else begin
      s9_vld_r  <= s8_vld_r;
      s10_vld_r <= s9_vld_r;
    end
    s9_prod_r <= MW'($signed({1'b0, s8_tw_r})) * MW'(DW'(s8_l_r[1]) - DW'(s8_l_r[0]));
    s9_lo_r   <= s8_l_r[0];
    s10_l_r   <= blend_add(s9_lo_r, s9_prod_r);
  end

  // ---------------- stage 11: offset, clamp, scale ----------------
  logic signed [GW:0] wsum;
  logic [F+1:0]       wclamp;
  logic [QW-1:0]      qv;
  logic               out_valid_r;
  logic [16:0]        out_noise_value_r;

  always_comb begin
    wsum = (GW+1)'(s10_l_r) + (GW+1)'(ONE_G);
    if (wsum < 0) begin
      wclamp = '0;
    end else if (wsum > TWO_G) begin
      wclamp = TWO_G[F+1:0];
    end else begin
      wclamp = wsum[F+1:0];
    end
    qv = {wclamp, 16'b0} >> (F + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s10_vld_r;
    end
    out_noise_value_r <= qv[16:0];
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_noise_value_r;

`ifndef SYNTHESIS
  a_no_result_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid) else $error("result strobe during table load");
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && !in_func, 11))
    else $error("result without an evaluate beat 11 cycles earlier");
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_noise_value <= 17'd65536)) else $error("noise value out of range");
`endif

endmodule
